/* src/pnpr_pkg.sv */
// shared widths, status codes and pipeline side-band type for the plane reflection block
// no dependencies
`timescale 1ns / 1ps
package pnpr_pkg;

  localparam int PT_W   = 32;            // Q16.16 coordinate
  localparam int NR_W   = 16;            // Q2.14 component
  localparam int S_W    = 50;            // n.p + d in Q.30, signed
  localparam int MAG_W  = 49;            // magnitude of s
  localparam int LO_W   = 25;            // low split of the magnitude
  localparam int HI_W   = MAG_W - LO_W;
  localparam int NUM_W  = 65;            // rounded dividend 2*|s|*|a| + den/2
  localparam int DEN_W  = 32;            // |n|^2 in Q.28
  localparam int Q_W    = 41;            // quotient bits kept before the clamp
  localparam int CORR_W = Q_W + 1;       // signed correction
  localparam int DIFF_W = CORR_W + 1;    // component minus correction
  localparam int LANES  = 6;             // three point lanes, three normal lanes
  localparam int DIV_LAT = Q_W + 1;      // divider latency in cycles

  localparam logic [1:0] REG_PLANE_A      = 2'd0;
  localparam logic [1:0] REG_PLANE_B      = 2'd1;
  localparam logic [1:0] REG_PLANE_C      = 2'd2;
  localparam logic [1:0] REG_PLANE_OFFSET = 2'd3;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_SAT   = 2'd1,
    STATUS_DEGEN = 2'd2
  } status_t;

  // data that rides alongside the arithmetic
  typedef struct packed {
    logic [2:0][PT_W-1:0] pt;
    logic [2:0][NR_W-1:0] nr;
    logic [LANES-1:0]     neg;
    logic                 degen;
  } side_t;

endpackage

/* src/pnpr_div.sv */
// pipelined restoring divider, one quotient bit per stage, with overflow detect
// depends on pnpr_pkg
`timescale 1ns / 1ps
module pnpr_div
  import pnpr_pkg::*;
(
  input  logic             clk,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   quo,
  output logic             ovf
);

  logic [DEN_W:0]   rem  [Q_W+1];
  logic [Q_W-1:0]   low  [Q_W+1];
  logic [Q_W-1:0]   qacc [Q_W+1];
  logic [DEN_W-1:0] dq   [Q_W+1];
  logic             of   [Q_W+1];

  always_ff @(posedge clk) begin
    rem[0]  <= (DEN_W+1)'(num[NUM_W-1:Q_W]);
    low[0]  <= num[Q_W-1:0];
    qacc[0] <= '0;
    dq[0]   <= den;
    of[0]   <= (DEN_W'(num[NUM_W-1:Q_W]) >= den);
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_step
    logic [DEN_W:0] trial;
    assign trial = {rem[k][DEN_W-1:0], low[k][Q_W-1]};
    always_ff @(posedge clk) begin
      if (trial >= {1'b0, dq[k]}) begin
        rem[k+1]  <= trial - {1'b0, dq[k]};
        qacc[k+1] <= {qacc[k][Q_W-2:0], 1'b1};
      end else begin
        rem[k+1]  <= trial;
        qacc[k+1] <= {qacc[k][Q_W-2:0], 1'b0};
      end
      low[k+1] <= {low[k][Q_W-2:0], 1'b0};
      dq[k+1]  <= dq[k];
      of[k+1]  <= of[k];
    end
  end

  assign quo = qacc[Q_W];
  assign ovf = of[Q_W];

endmodule

/* src/point_normal_plane_reflection.sv */
// top level: reflects a point and its surface normal across the configured plane
// depends on pnpr_pkg and pnpr_div
`timescale 1ns / 1ps
// usage
//   config: write plane_a/b/c (index 0..2, Q2.14) and plane_offset (index 3,
//   Q16.16) through cfg_valid/cfg_index/cfg_data; cfg_ready is always high.
//   write only while no transaction is in flight.
//   input: a transaction is taken on a clock edge with start high and busy low;
//   point_x/y/z and nrm_x/y/z are sampled there.
//   output: done pulses for one cycle with the mirrored point, mirrored normal
//   and status; the receiver cannot stall, so results are never held.
// pipeline
//   the accepting edge loads the first of seven front stages (capture,
//   products, sums, magnitudes, split multiplies, full product, rounding
//   offset), then the bit-per-stage divider (overflow check plus 41 quotient
//   bits), then clamp, subtract and saturate, whose registers load the
//   results together with done. one transaction per cycle while busy is low,
//   set by the fully pipelined divider lanes.
// reset
//   rst is synchronous; it empties the pipeline, restores the plane to
//   a=1.0 and holds busy high for the reset cycle.
module point_normal_plane_reflection
  import pnpr_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [PT_W-1:0]  point_x,
  input  logic signed [PT_W-1:0]  point_y,
  input  logic signed [PT_W-1:0]  point_z,
  input  logic signed [NR_W-1:0]  nrm_x,
  input  logic signed [NR_W-1:0]  nrm_y,
  input  logic signed [NR_W-1:0]  nrm_z,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [1:0]              cfg_index,
  input  logic [31:0]             cfg_data,
  output logic                    done,
  output logic signed [PT_W-1:0]  mirror_x,
  output logic signed [PT_W-1:0]  mirror_y,
  output logic signed [PT_W-1:0]  mirror_z,
  output logic signed [NR_W-1:0]  mirror_nrm_x,
  output logic signed [NR_W-1:0]  mirror_nrm_y,
  output logic signed [NR_W-1:0]  mirror_nrm_z,
  output logic [1:0]              status
);

  // plane registers
  logic signed [NR_W-1:0] plane_n [3];
  logic signed [PT_W-1:0] plane_offset;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_n[0]   <= 16'sd16384;
      plane_n[1]   <= '0;
      plane_n[2]   <= '0;
      plane_offset <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PLANE_A:      plane_n[0]   <= cfg_data[NR_W-1:0];
        REG_PLANE_B:      plane_n[1]   <= cfg_data[NR_W-1:0];
        REG_PLANE_C:      plane_n[2]   <= cfg_data[NR_W-1:0];
        REG_PLANE_OFFSET: plane_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) busy <= 1'b1;
    else     busy <= 1'b0;
  end

  logic accept;
  assign accept = start && !busy;

  // valid bits per front stage a..g
  logic [6:0] vld;
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else     vld <= {vld[5:0], accept};
  end

  // stage a: capture the transaction
  side_t side_a;
  always_ff @(posedge clk) begin
    side_a.pt    <= {point_z, point_y, point_x};
    side_a.nr    <= {nrm_z, nrm_y, nrm_x};
    side_a.neg   <= '0;
    side_a.degen <= 1'b0;
  end

  // stage b: products
  side_t side_b;
  logic signed [PT_W+NR_W-1:0] prod_p [3];
  logic signed [2*NR_W-1:0]    prod_r [3];
  logic signed [2*NR_W-1:0]    prod_n [3];
  always_ff @(posedge clk) begin
    side_b <= side_a;
    for (int i = 0; i < 3; i++) begin
      prod_p[i] <= plane_n[i] * $signed(side_a.pt[i]);
      prod_r[i] <= plane_n[i] * $signed(side_a.nr[i]);
      prod_n[i] <= plane_n[i] * plane_n[i];
    end
  end

  // stage c: sums
  side_t side_c;
  logic signed [S_W-1:0] s_c;
  logic signed [S_W-1:0] dr_c;
  logic [DEN_W-1:0]      den_c;
  always_ff @(posedge clk) begin
    side_c <= side_b;
    s_c    <= S_W'(prod_p[0]) + S_W'(prod_p[1]) + S_W'(prod_p[2])
            + (S_W'(plane_offset) <<< 14);
    dr_c   <= S_W'(prod_r[0]) + S_W'(prod_r[1]) + S_W'(prod_r[2]);
    den_c  <= DEN_W'(prod_n[0]) + DEN_W'(prod_n[1]) + DEN_W'(prod_n[2]);
  end

  // stage d: magnitudes and result signs
  side_t            side_d;
  logic [MAG_W-1:0] mag_d  [LANES];
  logic [NR_W-1:0]  maga_d [LANES];
  logic [DEN_W-1:0] den_d;
  logic [S_W-1:0]   s_abs, dr_abs;
  logic [LANES-1:0] neg_c;
  assign s_abs  = s_c[S_W-1]  ? (~s_c + 1'b1)  : s_c;
  assign dr_abs = dr_c[S_W-1] ? (~dr_c + 1'b1) : dr_c;

  // sign of each correction: sign of the dot product times sign of the plane term
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg_c[i]   = s_c[S_W-1]  ^ plane_n[i][NR_W-1];
      neg_c[i+3] = dr_c[S_W-1] ^ plane_n[i][NR_W-1];
    end
  end

  always_ff @(posedge clk) begin
    side_d.pt    <= side_c.pt;
    side_d.nr    <= side_c.nr;
    side_d.neg   <= neg_c;
    side_d.degen <= (den_c == '0);
    den_d        <= den_c;
    for (int i = 0; i < 3; i++) begin
      mag_d[i]          <= s_abs[MAG_W-1:0];
      mag_d[i+3]        <= dr_abs[MAG_W-1:0];
      maga_d[i]         <= plane_n[i][NR_W-1] ? (~plane_n[i] + 1'b1) : plane_n[i];
      maga_d[i+3]       <= plane_n[i][NR_W-1] ? (~plane_n[i] + 1'b1) : plane_n[i];
    end
  end

  // stage e: split partial products
  side_t                 side_e;
  logic [LO_W+NR_W-1:0]  pl_e [LANES];
  logic [HI_W+NR_W-1:0]  ph_e [LANES];
  logic [DEN_W-1:0]      den_e;
  always_ff @(posedge clk) begin
    side_e <= side_d;
    den_e  <= den_d;
    for (int i = 0; i < LANES; i++) begin
      pl_e[i] <= mag_d[i][LO_W-1:0] * maga_d[i];
      ph_e[i] <= mag_d[i][MAG_W-1:LO_W] * maga_d[i];
    end
  end

  // stage f: full product |s|*|a|
  side_t            side_f;
  logic [NUM_W-1:0] prod_f [LANES];
  logic [DEN_W-1:0] den_f;
  always_ff @(posedge clk) begin
    side_f <= side_e;
    den_f  <= den_e;
    for (int i = 0; i < LANES; i++) begin
      prod_f[i] <= (NUM_W'(ph_e[i]) << LO_W) + NUM_W'(pl_e[i]);
    end
  end

  // stage g: doubled product plus half divisor for round to nearest
  side_t            side_g;
  logic [NUM_W-1:0] num_g [LANES];
  logic [DEN_W-1:0] den_g;
  always_ff @(posedge clk) begin
    side_g <= side_f;
    den_g  <= den_f;
    for (int i = 0; i < LANES; i++) begin
      num_g[i] <= {prod_f[i][NUM_W-2:0], 1'b0} + NUM_W'(den_f >> 1);
    end
  end

  // divider lanes
  logic [Q_W-1:0] quo [LANES];
  logic           ovf [LANES];
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    pnpr_div u_div (
      .clk (clk),
      .num (num_g[i]),
      .den (den_g),
      .quo (quo[i]),
      .ovf (ovf[i])
    );
  end

  // side band and valid delayed to match the divider
  side_t side_dl [DIV_LAT];
  logic  [DIV_LAT-1:0] vld_dl;
  always_ff @(posedge clk) begin
    side_dl[0] <= side_g;
    for (int k = 1; k < DIV_LAT; k++) side_dl[k] <= side_dl[k-1];
  end
  always_ff @(posedge clk) begin
    if (rst) vld_dl <= '0;
    else     vld_dl <= {vld_dl[DIV_LAT-2:0], vld[6]};
  end

  // stage x: clamp quotient at 2^40 and apply sign
  side_t                   side_x;
  logic signed [CORR_W-1:0] corr_x [LANES];
  logic                    vld_x;
  logic [Q_W-1:0]          qclamp [LANES];
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      if (ovf[i] || (quo[i][Q_W-1] && (|quo[i][Q_W-2:0]))) begin
        qclamp[i] = {1'b1, {(Q_W-1){1'b0}}};
      end else begin
        qclamp[i] = quo[i];
      end
    end
  end
  always_ff @(posedge clk) begin
    side_x <= side_dl[DIV_LAT-1];
    for (int i = 0; i < LANES; i++) begin
      corr_x[i] <= side_dl[DIV_LAT-1].neg[i] ? -$signed({1'b0, qclamp[i]})
                                             :  $signed({1'b0, qclamp[i]});
    end
  end
  always_ff @(posedge clk) begin
    if (rst) vld_x <= 1'b0;
    else     vld_x <= vld_dl[DIV_LAT-1];
  end

  // stage y: subtract, saturate, pick status
  logic signed [DIFF_W-1:0] diff [LANES];
  logic [PT_W-1:0] mp_next [3];
  logic [NR_W-1:0] mr_next [3];
  logic            clip;
  status_t         status_next;
  always_comb begin
    clip = 1'b0;
    for (int i = 0; i < 3; i++) begin
      diff[i]   = DIFF_W'($signed(side_x.pt[i])) - DIFF_W'(corr_x[i]);
      diff[i+3] = DIFF_W'($signed(side_x.nr[i])) - DIFF_W'(corr_x[i+3]);
      if (diff[i] > DIFF_W'(33'sh0_7FFF_FFFF)) begin
        mp_next[i] = {1'b0, {(PT_W-1){1'b1}}};
        clip = 1'b1;
      end else if (diff[i] < -DIFF_W'(33'sh0_8000_0000)) begin
        mp_next[i] = {1'b1, {(PT_W-1){1'b0}}};
        clip = 1'b1;
      end else begin
        mp_next[i] = diff[i][PT_W-1:0];
      end
      if (diff[i+3] > DIFF_W'(17'sh0_7FFF)) begin
        mr_next[i] = {1'b0, {(NR_W-1){1'b1}}};
        clip = 1'b1;
      end else if (diff[i+3] < -DIFF_W'(17'sh0_8000)) begin
        mr_next[i] = {1'b1, {(NR_W-1){1'b0}}};
        clip = 1'b1;
      end else begin
        mr_next[i] = diff[i+3][NR_W-1:0];
      end
    end
    // degenerate plane: pass the transaction through untouched
    if (side_x.degen) begin
      for (int i = 0; i < 3; i++) begin
        mp_next[i] = side_x.pt[i];
        mr_next[i] = side_x.nr[i];
      end
      status_next = STATUS_DEGEN;
    end else if (clip) begin
      status_next = STATUS_SAT;
    end else begin
      status_next = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    mirror_x     <= mp_next[0];
    mirror_y     <= mp_next[1];
    mirror_z     <= mp_next[2];
    mirror_nrm_x <= mr_next[0];
    mirror_nrm_y <= mr_next[1];
    mirror_nrm_z <= mr_next[2];
    status       <= status_next;
  end
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= vld_x;
  end

endmodule
